/* design/ptfl_pkg.sv */
// Package for the page table with FIFO/LRU frame replacement.
// Holds the sequencer state type, register indexes, policy codes, reset values and fixed field widths.
// No dependencies.
`default_nettype none

package ptfl_pkg;

    // Fixed widths of the request and result fields.
    localparam int PAGE_W      = 10;
    localparam int FRAME_OUT_W = 4;
    localparam int TIME_W      = 32;

    // Configuration port.
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VPAGES  = 2'd2;

    // Replacement policy codes.
    localparam logic POL_FIFO = 1'b0;
    localparam logic POL_LRU  = 1'b1;

    // Register reset values.
    localparam logic [4:0]       FRAMES_RST = 5'd16;
    localparam logic [CFG_W-1:0] VPAGES_RST = 11'd1024;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_SCAN,
        S_VDRAIN,
        S_EVREAD,
        S_EVICT,
        S_LOAD
    } t_state;

endpackage

`default_nettype wire

/* design/ptfl_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module ptfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* design/page_table_fifo_lru_replacement.sv */
// Page table with FIFO or LRU frame replacement, top level.
// Depends on ptfl_pkg and ptfl_ram.
//
//   channel   direction  handshake               payload
//   request   in         start high, busy low    i_virtual_page
//   result    out        o_valid, one cycle      o_frame o_hit o_evicted_valid
//                                                o_evicted_page o_address_error
//   config    in         i_cfg_we                i_cfg_idx i_cfg_wdata
//
// A hit or an out-of-range page is answered without a scan. A miss scans the
// managed frames one per cycle up to the first free frame; with all managed
// frames full it scans every one of them through the frame time memories, which
// share a single comparator, and evicts the frame that comparator picks.
// After reset the block sweeps every entry of the page memory with busy high;
// configuration writes are taken at all times. The result cannot be stalled.
`default_nettype none

module page_table_fifo_lru_replacement
    import ptfl_pkg::*;
#(
    parameter int FRAMES = 16,
    parameter int VPAGES = 1024
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [PAGE_W-1:0]      i_virtual_page,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_W-1:0]       i_cfg_wdata,
    output logic                        o_valid,
    output logic [FRAME_OUT_W-1:0]      o_frame,
    output logic                        o_hit,
    output logic                        o_evicted_valid,
    output logic [PAGE_W-1:0]           o_evicted_page,
    output logic                        o_address_error
);

    localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int PW = (VPAGES > 1) ? $clog2(VPAGES) : 1;
    localparam int MW = FW + 1;
    localparam logic [PW-1:0] PG_LAST = PW'(VPAGES - 1);

    t_state r_state, n_state;

    // Configuration registers.
    logic             r_policy;
    logic [4:0]       r_frames;
    logic [CFG_W-1:0] r_vpages;

    // Control state.
    logic [TIME_W-1:0] r_clock;
    logic [FRAMES-1:0] r_frame_free;
    logic [PW-1:0]     r_clr_addr;
    logic              r_dv;
    logic              r_valid;

    // Working registers.
    logic [PAGE_W-1:0] r_page;
    logic [FW-1:0]     r_idx, r_didx, r_victim, r_frame;
    logic [TIME_W-1:0] r_best;

    // Result registers.
    logic [FRAME_OUT_W-1:0] r_o_frame;
    logic                   r_hit, r_ev_valid, r_aerr;
    logic [PAGE_W-1:0]      r_ev_page;

    // Memory ports.
    logic              map_we;
    logic [PW-1:0]     map_waddr, map_raddr;
    logic [MW-1:0]     map_wdata, map_rd;
    logic              use_we, load_we;
    logic [FW-1:0]     use_waddr, fr_raddr;
    logic [TIME_W-1:0] use_rd, load_rd;
    logic [PAGE_W-1:0] owner_rd;

    // Derived values.
    logic              accept, in_err, map_res, frame_is_free, better, tick;
    logic [31:0]       in_page32, page32, ev32, frames32, managed32, last32;
    logic [31:0]       map_frame32, r_frame32;
    logic [FW-1:0]     map_frame, scan_last;
    logic [PW-1:0]     in_addr, page_addr, ev_addr;
    logic              ev_in_range;
    logic [TIME_W-1:0] t_cur, clock_next;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Range check of the incoming page and memory addresses.
    assign in_page32 = 32'(i_virtual_page);
    assign in_err    = (in_page32 >= 32'(r_vpages)) || (in_page32 >= 32'(VPAGES));
    assign in_addr   = in_page32[PW-1:0];
    assign page32    = 32'(r_page);
    assign page_addr = page32[PW-1:0];

    // Page memory read data: resident mark on top, frame below.
    assign map_res     = map_rd[MW-1];
    assign map_frame   = map_rd[FW-1:0];
    assign map_frame32 = 32'(map_frame);
    assign r_frame32   = 32'(r_frame);

    // Evicted page from the owner memory.
    assign ev32        = 32'(owner_rd);
    assign ev_addr     = ev32[PW-1:0];
    assign ev_in_range = ev32 < 32'(VPAGES);

    // Number of managed frames, clamped to 1..FRAMES.
    assign frames32  = 32'(r_frames);
    assign managed32 = (frames32 == 32'd0) ? 32'd1 :
                       ((frames32 > 32'(FRAMES)) ? 32'(FRAMES) : frames32);
    assign last32    = managed32 - 32'd1;
    assign scan_last = last32[FW-1:0];

    // Shared comparator for the victim search.
    assign frame_is_free = r_frame_free[r_idx];
    assign t_cur  = (r_policy == POL_LRU) ? use_rd : load_rd;
    assign better = (r_didx == '0) || (t_cur < r_best);

    // Saturating access clock.
    assign clock_next = (r_clock == '1) ? r_clock : r_clock + 32'd1;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == PG_LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept && !in_err) n_state = S_LOOKUP;
            end
            S_LOOKUP: begin
                n_state = map_res ? S_IDLE : S_SCAN;
            end
            S_SCAN: begin
                if (frame_is_free) begin
                    n_state = S_LOAD;
                end else if (r_idx == scan_last) begin
                    n_state = S_VDRAIN;
                end
            end
            S_VDRAIN: n_state = S_EVREAD;
            S_EVREAD: n_state = S_EVICT;
            S_EVICT:  n_state = S_LOAD;
            S_LOAD:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Memory controls for each state.
    always_comb begin
        map_we    = 1'b0;
        map_waddr = page_addr;
        map_wdata = '0;
        map_raddr = in_addr;
        use_we    = 1'b0;
        use_waddr = r_frame;
        load_we   = 1'b0;
        fr_raddr  = r_idx;
        tick      = 1'b0;
        case (r_state)
            S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = r_clr_addr;
            end
            S_LOOKUP: begin
                if (map_res) begin
                    use_we    = 1'b1;
                    use_waddr = map_frame;
                    tick      = 1'b1;
                end
            end
            S_EVREAD: begin
                fr_raddr = r_frame;
            end
            S_EVICT: begin
                map_we    = ev_in_range;
                map_waddr = ev_addr;
            end
            S_LOAD: begin
                map_we    = 1'b1;
                map_wdata = {1'b1, r_frame};
                use_we    = 1'b1;
                load_we   = 1'b1;
                tick      = 1'b1;
            end
            default: ;
        endcase
    end

    // Page memory: resident mark and frame number for each page.
    ptfl_ram #(.WIDTH(MW), .DEPTH(VPAGES)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rd)
    );

    // Per-frame last-use time.
    ptfl_ram #(.WIDTH(TIME_W), .DEPTH(FRAMES)) u_use_ram (
        .i_clk   (i_clk),
        .i_we    (use_we),
        .i_waddr (use_waddr),
        .i_wdata (r_clock),
        .i_raddr (fr_raddr),
        .o_rdata (use_rd)
    );

    // Per-frame load time.
    ptfl_ram #(.WIDTH(TIME_W), .DEPTH(FRAMES)) u_load_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (r_frame),
        .i_wdata (r_clock),
        .i_raddr (fr_raddr),
        .o_rdata (load_rd)
    );

    // Per-frame owning page.
    ptfl_ram #(.WIDTH(PAGE_W), .DEPTH(FRAMES)) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (r_frame),
        .i_wdata (r_page),
        .i_raddr (fr_raddr),
        .o_rdata (owner_rd)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_policy     <= POL_FIFO;
            r_frames     <= FRAMES_RST;
            r_vpages     <= VPAGES_RST;
            r_clock      <= '0;
            r_frame_free <= '1;
            r_clr_addr   <= '0;
            r_dv         <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POLICY: r_policy <= i_cfg_wdata[0];
                    CFG_FRAMES: r_frames <= i_cfg_wdata[4:0];
                    CFG_VPAGES: r_vpages <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (tick) r_clock <= clock_next;
            if (r_state == S_CLEAR) r_clr_addr <= r_clr_addr + PW'(1);
            if (r_state == S_LOAD) r_frame_free[r_frame] <= 1'b0;
            if (r_state == S_LOOKUP) begin
                r_dv <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_dv <= 1'b1;
            end
            r_valid <= (accept && in_err) || (r_state == S_LOOKUP && map_res) ||
                       (r_state == S_LOAD);
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_page     <= i_virtual_page;
                    r_aerr     <= in_err;
                    r_o_frame  <= '0;
                    r_hit      <= 1'b0;
                    r_ev_valid <= 1'b0;
                    r_ev_page  <= '0;
                end
            end
            S_LOOKUP: begin
                r_idx  <= '0;
                r_didx <= '0;
                r_hit  <= map_res;
                if (map_res) r_o_frame <= map_frame32[FRAME_OUT_W-1:0];
            end
            S_SCAN: begin
                r_idx  <= r_idx + FW'(1);
                r_didx <= r_idx;
                if (r_dv && better) begin
                    r_best   <= t_cur;
                    r_victim <= r_didx;
                end
                if (frame_is_free) r_frame <= r_idx;
            end
            S_VDRAIN: begin
                // Last frame read is compared here; the winner becomes the victim.
                if (better) begin
                    r_victim <= r_didx;
                    r_frame  <= r_didx;
                end else begin
                    r_frame  <= r_victim;
                end
            end
            S_EVICT: begin
                r_ev_valid <= 1'b1;
                r_ev_page  <= owner_rd;
            end
            S_LOAD: begin
                r_o_frame <= r_frame32[FRAME_OUT_W-1:0];
            end
            default: ;
        endcase
    end

    assign o_valid         = r_valid;
    assign o_frame         = r_o_frame;
    assign o_hit           = r_hit;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_address_error = r_aerr;

    // A result is only given once the sequencer is back at rest.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobed while sequencer busy");

    // A hit never evicts, and an address error reports nothing else.
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && o_evicted_valid) &&
                    !(o_address_error && (o_hit || o_evicted_valid || o_frame != '0)))
        else $error("inconsistent result flags");

    // Every good request advances the access clock unless it is saturated.
    a_clock_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_address_error) |-> (r_clock != $past(r_clock, 2)) ||
                                           (r_clock == '1))
        else $error("access clock did not advance");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the page table with FIFO/LRU frame replacement.
// Predicts frame, hit and eviction for each accepted request and checks every result.
// Depends on ptfl_pkg and page_table_fifo_lru_replacement.
`default_nettype none

module testbench
    import ptfl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_FRAMES = 16;
    localparam int NUM_VPAGES = 1024;
    localparam int REPORT_LIMIT = 40;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [PAGE_W-1:0]    i_virtual_page = '0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_POLICY;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 o_valid;
    logic [FRAME_OUT_W-1:0] o_frame;
    logic                 o_hit;
    logic                 o_evicted_valid;
    logic [PAGE_W-1:0]    o_evicted_page;
    logic                 o_address_error;

    typedef struct packed {
        logic [FRAME_OUT_W-1:0] frame;
        logic                   hit;
        logic                   evicted_valid;
        logic [PAGE_W-1:0]      evicted_page;
        logic                   address_error;
    } t_page_result;

    // Mirror of the page table plus the queue of results still to come.
    class page_table_scoreboard;
        bit [FRAME_OUT_W-1:0] frame_of_page [NUM_VPAGES];
        bit                   page_mapped [NUM_VPAGES];
        bit                   frame_empty [NUM_FRAMES];
        bit [TIME_W-1:0]      loaded_at [NUM_FRAMES];
        bit [TIME_W-1:0]      used_at [NUM_FRAMES];
        bit [PAGE_W-1:0]      page_in_frame [NUM_FRAMES];
        bit [TIME_W-1:0]      now;
        logic                 policy;
        logic [4:0]           frame_limit;
        logic [CFG_W-1:0]     page_limit;
        t_page_result         pending[$];
        int                   errors;

        function new();
            for (int p = 0; p < NUM_VPAGES; p++) begin
                frame_of_page[p] = '0;
                page_mapped[p] = 1'b0;
            end
            for (int f = 0; f < NUM_FRAMES; f++) begin
                frame_empty[f] = 1'b1;
                loaded_at[f] = '0;
                used_at[f] = '0;
                page_in_frame[f] = '0;
            end
            now = '0;
            policy = POL_FIFO;
            frame_limit = FRAMES_RST;
            page_limit = VPAGES_RST;
            errors = 0;
        endfunction

        function void set_registers(logic pol, logic [4:0] fr, logic [CFG_W-1:0] vp);
            policy = pol;
            frame_limit = fr;
            page_limit = vp;
        endfunction

        // Works out the result of one accepted request and updates the mirror.
        function void note_request(logic [PAGE_W-1:0] page);
            t_page_result r;
            int n;
            int slot;
            bit placed;
            bit [TIME_W-1:0] best_age;
            bit [TIME_W-1:0] age;
            r = '0;
            slot = 0;
            if ({1'b0, page} >= page_limit) begin
                // Outside the page space: flagged, nothing changes.
                r.address_error = 1'b1;
                pending.push_back(r);
                return;
            end
            if (page_mapped[page]) begin
                slot = frame_of_page[page];
                r.hit = 1'b1;
                used_at[slot] = now;
            end else begin
                // A count of zero manages one frame, anything above the array all of them.
                n = (frame_limit == 0) ? 1 :
                    ((frame_limit > NUM_FRAMES) ? NUM_FRAMES : int'(frame_limit));
                placed = 1'b0;
                for (int f = 0; f < n && !placed; f++) begin
                    if (frame_empty[f]) begin
                        slot = f;
                        frame_empty[f] = 1'b0;
                        placed = 1'b1;
                    end
                end
                if (!placed) begin
                    // Oldest load or use time wins; the strict compare keeps the lowest index.
                    slot = 0;
                    best_age = (policy == POL_LRU) ? used_at[0] : loaded_at[0];
                    for (int f = 1; f < n; f++) begin
                        age = (policy == POL_LRU) ? used_at[f] : loaded_at[f];
                        if (age < best_age) begin
                            best_age = age;
                            slot = f;
                        end
                    end
                    r.evicted_valid = 1'b1;
                    r.evicted_page = page_in_frame[slot];
                    page_mapped[page_in_frame[slot]] = 1'b0;
                end
                frame_of_page[page] = FRAME_OUT_W'(slot);
                page_mapped[page] = 1'b1;
                page_in_frame[slot] = page;
                used_at[slot] = now;
                loaded_at[slot] = now;
            end
            r.frame = FRAME_OUT_W'(slot);
            // The access clock saturates instead of wrapping.
            if (now != '1)
                now = now + 1'b1;
            pending.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: %s mismatch: expected %0d, actual %0d",
                             $time, name, want, got);
            end
        endfunction

        function void check_result(t_page_result got);
            t_page_result want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: result without an outstanding request: %s %h",
                             $time, "expected none, actual", got);
                return;
            end
            want = pending.pop_front();
            compare_field("frame", 32'(want.frame), 32'(got.frame));
            compare_field("hit", 32'(want.hit), 32'(got.hit));
            compare_field("evicted_valid", 32'(want.evicted_valid), 32'(got.evicted_valid));
            compare_field("evicted_page", 32'(want.evicted_page), 32'(got.evicted_page));
            compare_field("address_error", 32'(want.address_error), 32'(got.address_error));
        endfunction
    endclass

    page_table_scoreboard sb = new();

    page_table_fifo_lru_replacement #(
        .FRAMES(NUM_FRAMES),
        .VPAGES(NUM_VPAGES)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_virtual_page(i_virtual_page),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .o_valid(o_valid),
        .o_frame(o_frame),
        .o_hit(o_hit),
        .o_evicted_valid(o_evicted_valid),
        .o_evicted_page(o_evicted_page),
        .o_address_error(o_address_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Results cannot be held off, so every strobe is checked at the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1)
            sb.check_result({o_frame, o_hit, o_evicted_valid, o_evicted_page, o_address_error});
    end

    // Mostly back-to-back or short pauses, now and then a long one.
    function automatic int pick_gap(bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Holds a request until the block takes it, then optionally idles.
    task automatic send_request(input logic [PAGE_W-1:0] page, input int gap);
        start <= 1'b1;
        i_virtual_page <= page;
        do @(posedge i_clk); while (busy);
        sb.note_request(page);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Writes all three registers on consecutive edges.
    task automatic apply_config(input logic pol, input logic [4:0] fr,
                                input logic [CFG_W-1:0] vp);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_POLICY;
        i_cfg_wdata <= CFG_W'(pol);
        @(posedge i_clk);
        i_cfg_idx <= CFG_FRAMES;
        i_cfg_wdata <= CFG_W'(fr);
        @(posedge i_clk);
        i_cfg_idx <= CFG_VPAGES;
        i_cfg_wdata <= vp;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_registers(pol, fr, vp);
    endtask

    // Stops issuing and waits until every outstanding request has its result.
    task automatic finish_phase();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic             pol;
        logic [4:0]       fr;
        logic [CFG_W-1:0] vp;
        logic [PAGE_W-1:0] page;
        int n;
        int lim;
        int span;
        int base;
        int count;
        int r;
        bit steady;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: both page extremes, hits, every frame filled, then
        // FIFO evictions where a recent hit does not save the oldest load.
        send_request(10'd0, 0);
        send_request(10'd1023, 1);
        send_request(10'd0, 0);
        send_request(10'd1023, 0);
        for (int p = 1; p <= 14; p++)
            send_request(PAGE_W'(p), p % 3);
        send_request(10'd200, 0);
        send_request(10'd1023, 2);
        send_request(10'd201, 0);
        finish_phase();

        // LRU: a refreshed frame survives and the stalest one is evicted.
        apply_config(POL_LRU, 5'd16, 11'd1024);
        send_request(10'd3, 0);
        send_request(10'd202, 0);
        finish_phase();

        // Shrunk frame count and page space: pages at or past the limit are errors,
        // and pages in frames above the count still hit.
        apply_config(POL_FIFO, 5'd2, 11'd600);
        send_request(10'd700, 0);
        send_request(10'd600, 0);
        send_request(10'd599, 1);
        send_request(10'd5, 0);
        finish_phase();

        // Random phases, the first ones pinned to the register extremes.
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: begin pol = POL_LRU;  fr = 5'd16; vp = 11'd1024; end
                1: begin pol = POL_FIFO; fr = 5'd1;  vp = 11'd1024; end
                2: begin pol = POL_LRU;  fr = 5'd1;  vp = 11'd1;    end
                3: begin pol = POL_FIFO; fr = 5'd16; vp = 11'd2047; end
                4: begin pol = POL_LRU;  fr = 5'd0;  vp = 11'd37;   end
                5: begin pol = POL_FIFO; fr = 5'd31; vp = 11'd1024; end
                6: begin pol = POL_LRU;  fr = 5'd5;  vp = 11'd0;    end
                default: begin
                    pol = ($urandom_range(0, 1) != 0) ? POL_LRU : POL_FIFO;
                    fr = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                     : 5'($urandom_range(1, 16));
                    r = $urandom_range(0, 9);
                    if (r < 3)
                        vp = 11'd1024;
                    else if (r < 6)
                        vp = 11'($urandom_range(1, 64));
                    else
                        vp = 11'($urandom_range(0, 2047));
                end
            endcase
            apply_config(pol, fr, vp);

            n = (fr == 0) ? 1 : ((fr > NUM_FRAMES) ? NUM_FRAMES : int'(fr));
            lim = (vp > NUM_VPAGES) ? NUM_VPAGES : int'(vp);
            count = (lim == 0) ? 8 : 44;
            steady = ($urandom_range(0, 3) == 0);
            span = 1;
            base = 0;

            for (int k = 0; k < count; k++) begin
                // A working set a little larger than the managed frames gives a mix
                // of hits and evictions; it moves now and then.
                if (k % 16 == 0 && lim > 0) begin
                    span = n + $urandom_range(0, n + 3);
                    if (span > lim)
                        span = lim;
                    base = (lim > span) ? $urandom_range(0, lim - span) : 0;
                end
                r = $urandom_range(0, 99);
                if (lim > 0 && r < 70)
                    page = PAGE_W'(base + $urandom_range(0, span - 1));
                else if (r < 85 || lim >= NUM_VPAGES)
                    page = PAGE_W'($urandom_range(0, NUM_VPAGES - 1));
                else
                    page = PAGE_W'($urandom_range(lim, NUM_VPAGES - 1));
                send_request(page, pick_gap(steady));
            end
            finish_phase();
        end

        repeat (40) @(posedge i_clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
design/ptfl_pkg.sv
design/ptfl_ram.sv
design/page_table_fifo_lru_replacement.sv
bench/testbench.sv
